/* sv/ocn_pkg.sv */
package ocn_pkg;

  localparam int COMP_FRAC_BITS = 14;
  localparam int NORM_GUARD     = 16;
  localparam int HW_W           = 5;
  localparam int CODE_W         = 32;
  localparam int COMP_W         = 16;
  localparam int HALF_MIN       = 2;
  localparam int HALF_MAX       = 16;
  localparam int HALF_RESET     = 8;
  localparam int LANES          = 3;

  localparam int DEN_W     = HALF_MAX - 1;
  localparam int MAG_W     = COMP_W + 1;
  localparam int PROD_W    = 32;
  localparam int N2_W      = 32;
  localparam int ROOT_W    = N2_W / 2 + NORM_GUARD;
  localparam int DVS_W     = ROOT_W + 1;
  localparam int QUOT_W    = COMP_FRAC_BITS + 2;
  localparam int NUM_SHIFT = COMP_FRAC_BITS + NORM_GUARD + 1;
  localparam int DVD_W     = DVS_W + QUOT_W - 1;

  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  typedef struct packed {
    logic             cmd;
    logic             zero;
    logic [LANES-1:0] neg;
  } ocn_tag_t;

  typedef struct packed {
    ocn_tag_t                     tag;
    logic [LANES-1:0][DVD_W-1:0]  num;
    logic [DVS_W-1:0]             dvs;
  } ocn_side_t;

  function automatic logic [HW_W-1:0] eff_half(input logic [HW_W-1:0] hw);
    logic [HW_W-1:0] h;
    h = hw;
    if (hw < HW_W'(HALF_MIN)) h = HW_W'(HALF_MIN);
    if (hw > HW_W'(HALF_MAX)) h = HW_W'(HALF_MAX);
    return h;
  endfunction

  function automatic logic [DEN_W-1:0] den_of(input logic [HW_W-1:0] he);
    logic [COMP_W:0] one;
    one = (COMP_W + 1)'(1) << (he - HW_W'(1));
    return DEN_W'(one - (COMP_W + 1)'(1));
  endfunction

  function automatic logic [COMP_W-1:0] mask_of(input logic [HW_W-1:0] he);
    logic [COMP_W:0] full;
    full = (COMP_W + 1)'(1) << he;
    return COMP_W'(full - (COMP_W + 1)'(1));
  endfunction

endpackage

/* sv/octahedral_normal_codec.sv */
// Octahedral normal codec. Each item carries cmd: encode turns a Q2.14 direction
// (vec_x/y/z) into a packed code word with two signed half_width-bit fields
// (u high, v low); decode turns code_in back into a unit Q2.14 direction. One item
// is taken per cycle while the output is not stalled. The pipeline holds 54
// registers: 4 front stages (abs, fold, multiply, sum), 32 square-root stages at
// one root bit each, 1 dividend stage, 16 divider stages at one quotient bit each
// and the output register. A stall on the output freezes the whole pipeline, so
// in_ready follows out_ready while the output register is full. half_width is
// clamped to 2..16 and may only be written while the pipeline is empty.
module octahedral_normal_codec (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ocn_pkg::HW_W-1:0]           cfg_half_width,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_cmd,
  input  logic signed [ocn_pkg::COMP_W-1:0]  in_vec_x,
  input  logic signed [ocn_pkg::COMP_W-1:0]  in_vec_y,
  input  logic signed [ocn_pkg::COMP_W-1:0]  in_vec_z,
  input  logic [ocn_pkg::CODE_W-1:0]         in_code_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ocn_pkg::CODE_W-1:0]         out_code_out,
  output logic signed [ocn_pkg::COMP_W-1:0]  out_dir_x,
  output logic signed [ocn_pkg::COMP_W-1:0]  out_dir_y,
  output logic signed [ocn_pkg::COMP_W-1:0]  out_dir_z
);
  import ocn_pkg::*;

  localparam logic [QUOT_W-1:0] ONE_Q = QUOT_W'(1) << COMP_FRAC_BITS;

  logic [HW_W-1:0] half_width_r;
  logic            en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_width_r <= HW_W'(HALF_RESET);
    end else if (cfg_valid) begin
      half_width_r <= cfg_half_width;
    end
  end

  assign en       = out_ready || !out_valid;
  assign in_ready = en;

  logic               fr_valid;
  logic [N2_W-1:0]    fr_n2;
  ocn_side_t          fr_side;

  ocn_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .half_width (half_width_r),
    .in_valid   (in_valid),
    .in_cmd     (in_cmd),
    .in_vec_x   (in_vec_x),
    .in_vec_y   (in_vec_y),
    .in_vec_z   (in_vec_z),
    .in_code_in (in_code_in),
    .out_valid  (fr_valid),
    .out_n2     (fr_n2),
    .out_side   (fr_side)
  );

  logic               sq_valid;
  logic [ROOT_W-1:0]  sq_root;
  ocn_side_t          sq_side;

  ocn_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_valid),
    .in_n2     (fr_n2),
    .in_side   (fr_side),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // dividend stage
  logic               dp_v_r;
  ocn_side_t          dp_side_r, dp_side_nxt;
  logic [ROOT_W-1:0]  s_val;

  always_comb begin
    s_val = (sq_root == '0) ? ROOT_W'(1) : sq_root;
    dp_side_nxt = sq_side;
    if (sq_side.tag.cmd == CMD_DECODE) begin
      for (int i = 0; i < LANES; i++) begin
        dp_side_nxt.num[i] = (DVD_W'(sq_side.num[i][DEN_W-1:0]) << NUM_SHIFT) + DVD_W'(s_val);
      end
      dp_side_nxt.dvs = {s_val, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dp_v_r <= 1'b0;
    end else if (en) begin
      dp_v_r <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dp_side_r <= dp_side_nxt;
    end
  end

  logic                          dv_valid;
  ocn_tag_t                      dv_tag;
  logic [LANES-1:0][QUOT_W-1:0]  dv_quot;

  ocn_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (dp_v_r),
    .in_side   (dp_side_r),
    .out_valid (dv_valid),
    .out_tag   (dv_tag),
    .out_quot  (dv_quot)
  );

  // output stage
  logic                          out_v_r;
  logic [CODE_W-1:0]             code_r, code_nxt;
  logic [LANES-1:0][COMP_W-1:0]  dir_r, dir_nxt;
  logic [HW_W-1:0]               he;
  logic [COMP_W-1:0]             mask;
  logic [COMP_W-1:0]             fu, fv;
  logic [QUOT_W-1:0]             qc;

  always_comb begin
    he   = eff_half(half_width_r);
    mask = mask_of(he);
    fu   = (dv_tag.neg[0] ? COMP_W'(-dv_quot[0]) : COMP_W'(dv_quot[0])) & mask;
    fv   = (dv_tag.neg[1] ? COMP_W'(-dv_quot[1]) : COMP_W'(dv_quot[1])) & mask;
    code_nxt = '0;
    dir_nxt  = '0;
    qc       = '0;
    if (dv_tag.cmd == CMD_DECODE) begin
      for (int i = 0; i < LANES; i++) begin
        qc = (dv_quot[i] > ONE_Q) ? ONE_Q : dv_quot[i];
        dir_nxt[i] = dv_tag.neg[i] ? COMP_W'(-qc) : COMP_W'(qc);
      end
    end else if (!dv_tag.zero) begin
      code_nxt = (CODE_W'(fu) << he) | CODE_W'(fv);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      code_r <= code_nxt;
      dir_r  <= dir_nxt;
    end
  end

  assign out_valid    = out_v_r;
  assign out_code_out = code_r;
  assign out_dir_x    = dir_r[0];
  assign out_dir_y    = dir_r[1];
  assign out_dir_z    = dir_r[2];

  a_code_or_dir : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_code_out == '0) ||
                  (out_dir_x == '0 && out_dir_y == '0 && out_dir_z == '0))
    else $error("result carries both a code and a direction");

  a_dir_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_dir_x >= -16'sd16384 && out_dir_x <= 16'sd16384 &&
                   out_dir_y >= -16'sd16384 && out_dir_y <= 16'sd16384 &&
                   out_dir_z >= -16'sd16384 && out_dir_z <= 16'sd16384))
    else $error("direction component beyond unit range");

  a_stall_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while output stalled");

endmodule

/* sv/ocn_front.sv */
module ocn_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic [ocn_pkg::HW_W-1:0]    half_width,
  input  logic                        in_valid,
  input  logic                        in_cmd,
  input  logic signed [ocn_pkg::COMP_W-1:0] in_vec_x,
  input  logic signed [ocn_pkg::COMP_W-1:0] in_vec_y,
  input  logic signed [ocn_pkg::COMP_W-1:0] in_vec_z,
  input  logic [ocn_pkg::CODE_W-1:0]  in_code_in,
  output logic                        out_valid,
  output logic [ocn_pkg::N2_W-1:0]    out_n2,
  output ocn_pkg::ocn_side_t          out_side
);
  import ocn_pkg::*;

  function automatic logic [DEN_W-1:0] fld_mag(input logic [COMP_W-1:0] raw, input logic neg,
                                               input logic [HW_W-1:0] he,
                                               input logic [DEN_W-1:0] den);
    logic [COMP_W:0] full;
    logic [COMP_W:0] m;
    full = (COMP_W + 1)'(1) << he;
    m = neg ? full - {1'b0, raw} : {1'b0, raw};
    if (m > (COMP_W + 1)'(den)) m = (COMP_W + 1)'(den);
    return DEN_W'(m);
  endfunction

  logic [HW_W-1:0]   he;
  logic [DEN_W-1:0]  den;
  logic [COMP_W-1:0] mask;
  logic [3:0]        sbit;
  logic [COMP_W-1:0] u_raw, v_raw;

  // stage 1: magnitudes and signs
  logic                          s1_v_r, s1_cmd_r, s1_cmd_nxt;
  logic [LANES-1:0]              s1_neg_r, s1_neg_nxt;
  logic [LANES-1:0][COMP_W-1:0]  s1_a_r, s1_a_nxt;

  always_comb begin
    he    = eff_half(half_width);
    den   = den_of(he);
    mask  = mask_of(he);
    sbit  = 4'(he - HW_W'(1));
    u_raw = COMP_W'(in_code_in >> he) & mask;
    v_raw = in_code_in[COMP_W-1:0] & mask;
    s1_cmd_nxt = in_cmd;
    if (in_cmd == CMD_DECODE) begin
      s1_neg_nxt = {1'b0, v_raw[sbit], u_raw[sbit]};
      s1_a_nxt[0] = COMP_W'(fld_mag(u_raw, u_raw[sbit], he, den));
      s1_a_nxt[1] = COMP_W'(fld_mag(v_raw, v_raw[sbit], he, den));
      s1_a_nxt[2] = '0;
    end else begin
      s1_neg_nxt = {in_vec_z[COMP_W-1], in_vec_y[COMP_W-1], in_vec_x[COMP_W-1]};
      s1_a_nxt[0] = in_vec_x[COMP_W-1] ? COMP_W'(-in_vec_x) : COMP_W'(in_vec_x);
      s1_a_nxt[1] = in_vec_y[COMP_W-1] ? COMP_W'(-in_vec_y) : COMP_W'(in_vec_y);
      s1_a_nxt[2] = in_vec_z[COMP_W-1] ? COMP_W'(-in_vec_z) : COMP_W'(in_vec_z);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_cmd_r <= s1_cmd_nxt;
      s1_neg_r <= s1_neg_nxt;
      s1_a_r   <= s1_a_nxt;
    end
  end

  // stage 2: l1 norm, fold
  logic                          s2_v_r;
  ocn_tag_t                      s2_tag_r, s2_tag_nxt;
  logic [LANES-1:0][MAG_W-1:0]   s2_m_r, s2_m_nxt;
  logic [MAG_W-1:0]              s2_l1_r, s2_l1_nxt;
  logic [MAG_W-1:0]              dsum;
  logic                          zfold;

  always_comb begin
    dsum = MAG_W'(s1_a_r[0]) + MAG_W'(s1_a_r[1]);
    zfold = dsum > MAG_W'(den);
    s2_tag_nxt.cmd = s1_cmd_r;
    s2_l1_nxt = dsum + MAG_W'(s1_a_r[2]);
    if (s1_cmd_r == CMD_DECODE) begin
      s2_tag_nxt.zero = 1'b0;
      s2_tag_nxt.neg  = {zfold, s1_neg_r[1:0]};
      s2_m_nxt[0] = zfold ? MAG_W'(den) - MAG_W'(s1_a_r[1]) : MAG_W'(s1_a_r[0]);
      s2_m_nxt[1] = zfold ? MAG_W'(den) - MAG_W'(s1_a_r[0]) : MAG_W'(s1_a_r[1]);
      s2_m_nxt[2] = zfold ? dsum - MAG_W'(den) : MAG_W'(den) - dsum;
    end else begin
      s2_tag_nxt.zero = (s2_l1_nxt == '0);
      s2_tag_nxt.neg  = {1'b0, s1_neg_r[1:0]};
      s2_m_nxt[0] = s1_neg_r[2] ? MAG_W'(s1_a_r[0]) + MAG_W'(s1_a_r[2]) : MAG_W'(s1_a_r[0]);
      s2_m_nxt[1] = s1_neg_r[2] ? MAG_W'(s1_a_r[1]) + MAG_W'(s1_a_r[2]) : MAG_W'(s1_a_r[1]);
      s2_m_nxt[2] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_tag_r <= s2_tag_nxt;
      s2_m_r   <= s2_m_nxt;
      s2_l1_r  <= s2_l1_nxt;
    end
  end

  // stage 3: products
  logic                          s3_v_r;
  ocn_tag_t                      s3_tag_r;
  logic [LANES-1:0][MAG_W-1:0]   s3_m_r;
  logic [MAG_W-1:0]              s3_l1_r;
  logic [LANES-1:0][PROD_W-1:0]  s3_p_r, s3_p_nxt;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      s3_p_nxt[i] = PROD_W'(s2_m_r[i] *
                    ((s2_tag_r.cmd == CMD_DECODE) ? s2_m_r[i] : MAG_W'(den)));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_tag_r <= s2_tag_r;
      s3_m_r   <= s2_m_r;
      s3_l1_r  <= s2_l1_r;
      s3_p_r   <= s3_p_nxt;
    end
  end

  // stage 4: dividends or sum of squares
  logic                 s4_v_r;
  ocn_side_t            s4_side_r, s4_side_nxt;
  logic [N2_W-1:0]      s4_n2_r, s4_n2_nxt;

  always_comb begin
    s4_side_nxt.tag = s3_tag_r;
    if (s3_tag_r.cmd == CMD_DECODE) begin
      s4_n2_nxt = N2_W'(s3_p_r[0]) + N2_W'(s3_p_r[1]) + N2_W'(s3_p_r[2]);
      for (int i = 0; i < LANES; i++) s4_side_nxt.num[i] = DVD_W'(s3_m_r[i]);
      s4_side_nxt.dvs = '0;
    end else begin
      s4_n2_nxt = '0;
      for (int i = 0; i < LANES - 1; i++) begin
        s4_side_nxt.num[i] = DVD_W'({s3_p_r[i], 1'b0}) + DVD_W'(s3_l1_r);
      end
      s4_side_nxt.num[LANES-1] = '0;
      s4_side_nxt.dvs = DVS_W'({s3_l1_r, 1'b0});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_side_r <= s4_side_nxt;
      s4_n2_r   <= s4_n2_nxt;
    end
  end

  assign out_valid = s4_v_r;
  assign out_n2    = s4_n2_r;
  assign out_side  = s4_side_r;

endmodule

/* sv/ocn_sqrt.sv */
module ocn_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [ocn_pkg::N2_W-1:0]   in_n2,
  input  ocn_pkg::ocn_side_t         in_side,
  output logic                       out_valid,
  output logic [ocn_pkg::ROOT_W-1:0] out_root,
  output ocn_pkg::ocn_side_t         out_side
);
  import ocn_pkg::*;

  localparam int REM_W = ROOT_W + 2;

  logic [ROOT_W-1:0] v_r;
  logic [N2_W-1:0]   rad_r  [ROOT_W];
  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  ocn_side_t         side_r [ROOT_W];

  logic [N2_W-1:0]   rad_nxt  [ROOT_W];
  logic [REM_W-1:0]  rem_nxt  [ROOT_W];
  logic [ROOT_W-1:0] root_nxt [ROOT_W];

  // one result bit per stage, radicand is n2 followed by zero pairs
  for (genvar i = 0; i < ROOT_W; i++) begin : g_st
    logic [N2_W-1:0]   rad_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic              vin;
    ocn_side_t         sin;

    if (i == 0) begin : g_first
      assign rad_in  = in_n2;
      assign rem_in  = '0;
      assign root_in = '0;
      assign vin     = in_valid;
      assign sin     = in_side;
    end else begin : g_next
      assign rad_in  = rad_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign vin     = v_r[i-1];
      assign sin     = side_r[i-1];
    end

    always_comb begin
      rem_sh = {rem_in, rad_in[N2_W-1 -: 2]};
      trial  = (REM_W + 2)'({root_in, 2'b01});
      rad_nxt[i] = {rad_in[N2_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt[i]  = REM_W'(rem_sh - trial);
        root_nxt[i] = {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt[i]  = REM_W'(rem_sh);
        root_nxt[i] = {root_in[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[i]  <= rad_nxt[i];
        rem_r[i]  <= rem_nxt[i];
        root_r[i] <= root_nxt[i];
        side_r[i] <= sin;
      end
    end
  end

  assign out_valid = v_r[ROOT_W-1];
  assign out_root  = root_r[ROOT_W-1];
  assign out_side  = side_r[ROOT_W-1];

endmodule

/* sv/ocn_div.sv */
module ocn_div (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           en,
  input  logic                                           in_valid,
  input  ocn_pkg::ocn_side_t                             in_side,
  output logic                                           out_valid,
  output ocn_pkg::ocn_tag_t                              out_tag,
  output logic [ocn_pkg::LANES-1:0][ocn_pkg::QUOT_W-1:0] out_quot
);
  import ocn_pkg::*;

  logic [QUOT_W-1:0]                  v_r;
  ocn_tag_t                           tag_r [QUOT_W];
  logic [DVS_W-1:0]                   dvs_r [QUOT_W];
  logic [LANES-1:0][DVD_W-1:0]        rem_r [QUOT_W];
  logic [LANES-1:0][QUOT_W-1:0]       q_r   [QUOT_W];

  logic [LANES-1:0][DVD_W-1:0]        rem_nxt [QUOT_W];
  logic [LANES-1:0][QUOT_W-1:0]       q_nxt   [QUOT_W];

  // restoring division, one quotient bit per stage, three lanes share the divisor
  for (genvar k = 0; k < QUOT_W; k++) begin : g_st
    logic                           vin;
    ocn_tag_t                       tin;
    logic [DVS_W-1:0]               din;
    logic [LANES-1:0][DVD_W-1:0]    rin;
    logic [LANES-1:0][QUOT_W-1:0]   qin;
    logic [DVD_W-1:0]               cmp;

    if (k == 0) begin : g_first
      assign vin = in_valid;
      assign tin = in_side.tag;
      assign din = in_side.dvs;
      assign rin = in_side.num;
      assign qin = '0;
    end else begin : g_next
      assign vin = v_r[k-1];
      assign tin = tag_r[k-1];
      assign din = dvs_r[k-1];
      assign rin = rem_r[k-1];
      assign qin = q_r[k-1];
    end

    always_comb begin
      cmp = DVD_W'(din) << (QUOT_W - 1 - k);
      for (int i = 0; i < LANES; i++) begin
        if (rin[i] >= cmp) begin
          rem_nxt[k][i] = rin[i] - cmp;
          q_nxt[k][i]   = {qin[i][QUOT_W-2:0], 1'b1};
        end else begin
          rem_nxt[k][i] = rin[i];
          q_nxt[k][i]   = {qin[i][QUOT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_r[k] <= tin;
        dvs_r[k] <= din;
        rem_r[k] <= rem_nxt[k];
        q_r[k]   <= q_nxt[k];
      end
    end
  end

  assign out_valid = v_r[QUOT_W-1];
  assign out_tag   = tag_r[QUOT_W-1];
  assign out_quot  = q_r[QUOT_W-1];

endmodule

/* tb/octahedral_normal_codec_tb.sv */
module octahedral_normal_codec_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ocn_pkg::*;

  typedef struct {
    logic [CODE_W-1:0] code;
    logic [COMP_W-1:0] dx;
    logic [COMP_W-1:0] dy;
    logic [COMP_W-1:0] dz;
  } codec_result_t;

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [HW_W-1:0] cfg_half_width;
  logic in_valid;
  logic in_ready;
  logic in_cmd;
  logic signed [COMP_W-1:0] in_vec_x, in_vec_y, in_vec_z;
  logic [CODE_W-1:0] in_code_in;
  logic out_valid;
  logic out_ready;
  logic [CODE_W-1:0] out_code_out;
  logic signed [COMP_W-1:0] out_dir_x, out_dir_y, out_dir_z;

  octahedral_normal_codec dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_half_width(cfg_half_width),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
    .in_vec_x(in_vec_x), .in_vec_y(in_vec_y), .in_vec_z(in_vec_z),
    .in_code_in(in_code_in),
    .out_valid(out_valid), .out_ready(out_ready), .out_code_out(out_code_out),
    .out_dir_x(out_dir_x), .out_dir_y(out_dir_y), .out_dir_z(out_dir_z)
  );

  codec_result_t expected_q[$];
  logic [HW_W-1:0] model_half;
  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int results_seen;
  int encodes_sent;
  int decodes_sent;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint abs64(input longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [CODE_W-1:0] quantize(input longint n, input longint l1,
                                                 input longint d, input longint unsigned m);
    longint q;
    q = (2 * abs64(n) * d + l1) / (2 * l1);
    if (q > d) q = d;
    if (n < 0) q = -q;
    return CODE_W'(q & m);
  endfunction

  function automatic logic [COMP_W-1:0] unit_comp(input longint c, input longint s);
    longint q;
    q = ((abs64(c) << (COMP_FRAC_BITS + NORM_GUARD)) * 2 + s) / (2 * s);
    if (q > (64'sd1 << COMP_FRAC_BITS)) q = 64'sd1 << COMP_FRAC_BITS;
    if (c < 0) q = -q;
    return COMP_W'(q);
  endfunction

  function automatic codec_result_t predict_codec(input logic cmd,
                                                  input logic signed [COMP_W-1:0] x,
                                                  input logic signed [COMP_W-1:0] y,
                                                  input logic signed [COMP_W-1:0] z,
                                                  input logic [CODE_W-1:0] cw);
    codec_result_t r;
    int h;
    longint d, l1, nu, nv, u, v, zc, fu, fv, s;
    longint unsigned m, n2;
    h = model_half;
    if (h < HALF_MIN) h = HALF_MIN;
    if (h > HALF_MAX) h = HALF_MAX;
    d = (64'sd1 << (h - 1)) - 1;
    m = (64'd1 << h) - 1;
    r.code = '0;
    r.dx = '0;
    r.dy = '0;
    r.dz = '0;
    if (cmd == CMD_ENCODE) begin
      l1 = abs64(x) + abs64(y) + abs64(z);
      if (l1 != 0) begin
        nu = x;
        nv = y;
        if (z < 0) begin
          nu = (l1 - abs64(y)) * (x >= 0 ? 1 : -1);
          nv = (l1 - abs64(x)) * (y >= 0 ? 1 : -1);
        end
        r.code = (quantize(nu, l1, d, m) << h) | quantize(nv, l1, d, m);
      end
    end else begin
      u = longint'((cw >> h) & m);
      v = longint'(cw & m);
      if (u >= (64'sd1 << (h - 1))) u = u - (64'sd1 << h);
      if (v >= (64'sd1 << (h - 1))) v = v - (64'sd1 << h);
      if (u < -d) u = -d;
      if (v < -d) v = -d;
      zc = d - abs64(u) - abs64(v);
      if (zc < 0) begin
        fu = (d - abs64(v)) * (u >= 0 ? 1 : -1);
        fv = (d - abs64(u)) * (v >= 0 ? 1 : -1);
        u = fu;
        v = fv;
      end
      n2 = u * u + v * v + zc * zc;
      s = int_sqrt(n2 << (2 * NORM_GUARD));
      if (s == 0) s = 1;
      r.dx = unit_comp(u, s);
      r.dy = unit_comp(v, s);
      r.dz = unit_comp(zc, s);
    end
    return r;
  endfunction

  task automatic send_item(input logic cmd, input logic signed [COMP_W-1:0] x,
                           input logic signed [COMP_W-1:0] y,
                           input logic signed [COMP_W-1:0] z, input logic [CODE_W-1:0] cw);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_vec_x <= x;
    in_vec_y <= y;
    in_vec_z <= z;
    in_code_in <= cw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.insert(expected_q.size(), predict_codec(cmd, x, y, z, cw));
    if (cmd == CMD_ENCODE) encodes_sent++;
    else decodes_sent++;
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain_pipeline();
    release_input();
    while (expected_q.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_half_width(input logic [HW_W-1:0] hw);
    drain_pipeline();
    cfg_valid <= 1'b1;
    cfg_half_width <= hw;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model_half = hw;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [COMP_W-1:0] rand_comp();
    case ($urandom_range(5))
      0: return COMP_W'(0);
      1: return 16'sd16384;
      2: return -16'sd16384;
      3: return COMP_W'($urandom);
      default: return COMP_W'($urandom_range(32768)) - 16'sd16384;
    endcase
  endfunction

  task automatic send_random_item();
    send_item(1'($urandom), rand_comp(), rand_comp(), rand_comp(), $urandom);
  endtask

  task automatic test_directed_encode();
    send_item(CMD_ENCODE, 0, 0, 0, '1);
    send_item(CMD_ENCODE, 16384, 0, 0, 0);
    send_item(CMD_ENCODE, -16384, 0, 0, 0);
    send_item(CMD_ENCODE, 0, 16384, 0, 0);
    send_item(CMD_ENCODE, 0, 0, 16384, 0);
    send_item(CMD_ENCODE, 0, 0, -16384, 0);
    send_item(CMD_ENCODE, 0, -5, -7, 0);
    send_item(CMD_ENCODE, -3, 0, -9, 0);
    send_item(CMD_ENCODE, 16'sh7fff, 16'sh8000, 16'sh7fff, 0);
    send_item(CMD_ENCODE, 16'sh8000, 16'sh8000, 16'sh8000, 0);
    send_item(CMD_ENCODE, 1, 1, -1, 32'hffff_ffff);
    send_item(CMD_ENCODE, 16'sh5555, 16'shaaaa, 16'sh1234, 0);
  endtask

  task automatic test_directed_decode();
    send_item(CMD_DECODE, 0, 0, 0, 32'h0000_0000);
    send_item(CMD_DECODE, 0, 0, 0, 32'hffff_ffff);
    send_item(CMD_DECODE, 0, 0, 0, 32'h0000_8080);
    send_item(CMD_DECODE, 0, 0, 0, 32'h0000_7f7f);
    send_item(CMD_DECODE, 0, 0, 0, 32'h0000_7f00);
    send_item(CMD_DECODE, 0, 0, 0, 32'h0000_817f);
    send_item(CMD_DECODE, 0, 0, 0, 32'haaaa_5555);
    send_item(CMD_DECODE, 16'sh7fff, 16'sh8000, 16'sh1, 32'h5555_aaaa);
  endtask

  task automatic test_random_phase(input int n, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (n) send_random_item();
  endtask

  task automatic test_half_width_sweep();
    logic [HW_W-1:0] widths[8];
    widths = '{5'd0, 5'd1, 5'd2, 5'd3, 5'd16, 5'd17, 5'd31, 5'd11};
    foreach (widths[i]) begin
      write_half_width(widths[i]);
      repeat (6) send_item(CMD_DECODE, 0, 0, 0, $urandom);
      send_item(CMD_DECODE, 0, 0, 0, 32'hffff_ffff);
      send_item(CMD_DECODE, 0, 0, 0, 32'h8000_8000);
      repeat (6) send_item(CMD_ENCODE, rand_comp(), rand_comp(), rand_comp(), 0);
      test_random_phase(40, 32, 63);
    end
  endtask

  task automatic test_stream_pause();
    repeat (30) send_random_item();
    release_input();
    while (expected_q.size() != 0) @(negedge clk);
    repeat (30) send_random_item();
  endtask

  always @(posedge clk) begin
    codec_result_t e;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: code %h", out_code_out);
      end else begin
        e = expected_q.pop_front();
        if (out_code_out !== e.code || out_dir_x !== e.dx || out_dir_y !== e.dy ||
            out_dir_z !== e.dz) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h %h %h %h got %h %h %h %h", e.code, e.dx, e.dy,
                     e.dz, out_code_out, out_dir_x, out_dir_y, out_dir_z);
        end
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    #20ms;
    $display("FAIL octahedral_normal_codec");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_half_width = '0;
    in_valid = 1'b0;
    in_cmd = CMD_ENCODE;
    in_vec_x = '0;
    in_vec_y = '0;
    in_vec_z = '0;
    in_code_in = '0;
    out_ready = 1'b0;
    model_half = HW_W'(HALF_RESET);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    mismatches = 0;
    results_seen = 0;
    encodes_sent = 0;
    decodes_sent = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_encode();
    test_directed_decode();
    test_half_width_sweep();
    write_half_width(5'd16);
    test_random_phase(250, 32, 63);
    write_half_width(5'd2);
    test_random_phase(100, 63, 32);
    write_half_width(5'd8);
    test_random_phase(150, 63, 32);
    test_stream_pause();
    test_random_phase(150, 0, 0);
    drain_pipeline();
    $display("covered %0d encodes and %0d decodes over half widths 0..31, %0d results",
             encodes_sent, decodes_sent, results_seen);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("PASS octahedral_normal_codec");
    end else begin
      $display("FAIL octahedral_normal_codec");
    end
    $finish;
  end

endmodule

/* octahedral_normal_codec.f */
sv/ocn_pkg.sv
sv/ocn_front.sv
sv/ocn_sqrt.sv
sv/ocn_div.sv
sv/octahedral_normal_codec.sv
tb/octahedral_normal_codec_tb.sv
